### src/pss_pkg.sv
// Shared types and constants for the point sprite projection and setup block.
// No dependencies; pss_req_if, pss_div3 and the core use this package by scoped names.
package pss_pkg;

   // default widths of the matrix coefficients and the input coordinates
   localparam int COEF_WIDTH_DEF  = 16;
   localparam int POINT_WIDTH_DEF = 24;

   // quotients are taken in 1/16 pixel: numerator is scaled by 2^4
   localparam int SUBPIX_SHIFT = 4;

   // size divisor 16 * 256 * 5536 = 2^17 * 173
   localparam int SIZE_SHIFT = 17;
   localparam int SIZE_ODD   = 173;
   // ceil(u / 173) taken as floor((u + 172) * RECIP >> 32), exact for u below U_CLAMP
   localparam logic [24:0] SIZE_RECIP = 25'd24826402;
   localparam int RECIP_SHIFT = 32;
   localparam logic [23:0] U_CLAMP = 24'(SIZE_ODD * 65536);

   // reset values of the size registers
   localparam logic [15:0] MAX_SIZE_RST = 16'd448;
   localparam logic [15:0] FALLOFF_RST  = 16'd768;

   // register map index (byte address 8 * index)
   typedef enum logic [2:0] {
      REG_ROW0    = 3'd0,
      REG_ROW1    = 3'd1,
      REG_ROW2    = 3'd2,
      REG_ROW3    = 3'd3,
      REG_MAXSIZE = 3'd4,
      REG_FALLOFF = 3'd5
   } reg_idx_type;

   // per-request sign and zero info carried alongside the divider
   typedef struct packed {
      logic       w_zero;
      logic       w_neg;
      logic [2:0] num_neg;
      logic [2:0] num_zero;
      logic       last;
   } side_type;

endpackage

### src/pss_req_if.sv
// Input channel of the point sprite block: valid/ready plus one point.
// Uses pss_pkg for the default coordinate width.
interface pss_req_if #(
   parameter int POINT_WIDTH = pss_pkg::POINT_WIDTH_DEF
) ();
   logic                          valid;
   logic                          ready;
   logic signed [POINT_WIDTH-1:0] point_x;
   logic signed [POINT_WIDTH-1:0] point_y;
   logic signed [POINT_WIDTH-1:0] point_z;
   logic signed [POINT_WIDTH-1:0] point_w;
   logic                          last_point;

   modport source (output valid, point_x, point_y, point_z, point_w, last_point,
                   input ready);
   modport sink   (input valid, point_x, point_y, point_z, point_w, last_point,
                   output ready);
endinterface

### src/pss_rsp_if.sv
// Result channel of the point sprite block: valid/ready plus one sprite.
// No dependencies.
interface pss_rsp_if ();
   logic        valid;
   logic        ready;
   logic [15:0] corner0_x;
   logic [15:0] corner0_y;
   logic [15:0] corner1_x;
   logic [15:0] corner1_y;
   logic [31:0] depth;
   logic [15:0] half_size;
   logic        range_flag;
   logic        last_sprite;

   modport source (output valid, corner0_x, corner0_y, corner1_x, corner1_y, depth,
                   half_size, range_flag, last_sprite, input ready);
   modport sink   (input valid, corner0_x, corner0_y, corner1_x, corner1_y, depth,
                   half_size, range_flag, last_sprite, output ready);
endinterface

### src/pss_div3.sv
// Pipelined restoring divider: three unsigned numerators over one shared
// denominator, one quotient bit per stage. Uses pss_pkg::side_type.
module pss_div3 #(
   parameter int NW = 46,
   parameter int DW = 42
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  pss_pkg::side_type       in_side,
   input  logic [2:0][NW-1:0]      in_num,
   input  logic [DW-1:0]           in_den,
   output logic                    out_valid,
   output pss_pkg::side_type       out_side,
   output logic [2:0][NW-1:0]      out_quo
);

   logic                    v_ff    [NW];
   logic [DW-1:0]           den_ff  [NW];
   pss_pkg::side_type       side_ff [NW];
   logic [2:0][NW-1:0]      nq_ff   [NW];
   logic [2:0][DW-1:0]      rem_ff  [NW];

   for (genvar s = 0; s < NW; s++) begin : g_stage
      logic                    v_src;
      logic [DW-1:0]           den_src;
      pss_pkg::side_type       side_src;
      logic [2:0][NW-1:0]      nq_src;
      logic [2:0][DW-1:0]      rem_src;
      logic [2:0][NW-1:0]      nq_in;
      logic [2:0][DW-1:0]      rem_in;

      if (s == 0) begin : g_first
         assign v_src    = in_valid;
         assign den_src  = in_den;
         assign side_src = in_side;
         assign nq_src   = in_num;
         assign rem_src  = '0;
      end else begin : g_next
         assign v_src    = v_ff[s-1];
         assign den_src  = den_ff[s-1];
         assign side_src = side_ff[s-1];
         assign nq_src   = nq_ff[s-1];
         assign rem_src  = rem_ff[s-1];
      end

      // shift in the next numerator bit, subtract when it fits
      always_comb begin
         logic [DW:0] trial;
         logic [DW:0] diff;
         logic        ge;
         for (int l = 0; l < 3; l++) begin
            trial = {rem_src[l], nq_src[l][NW-1]};
            diff  = trial - {1'b0, den_src};
            ge    = (trial >= {1'b0, den_src});
            rem_in[l] = ge ? diff[DW-1:0] : trial[DW-1:0];
            nq_in[l]  = {nq_src[l][NW-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (en) begin
            v_ff[s] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            den_ff[s]  <= den_src;
            side_ff[s] <= side_src;
            nq_ff[s]   <= nq_in;
            rem_ff[s]  <= rem_in;
         end
      end
   end

   assign out_valid = v_ff[NW-1];
   assign out_side  = side_ff[NW-1];
   assign out_quo   = nq_ff[NW-1];

endmodule

### src/point_sprite_project_setup_core.sv
// Point sprite projection and setup. Each request (x, y, z, w) goes through a
// 4x4 coefficient matrix, a divide by the projected w, a depth based size
// falloff and corner clamping. One request is accepted every clock cycle
// while no result waits at the output. The pipeline is the bit-per-stage
// divider plus three setup and six finishing stages.
// The whole pipeline holds while a result waits at the output. Registers
// are written over the APB port at byte address 8 * index.
module point_sprite_project_setup_core #(
   parameter int COEF_WIDTH  = pss_pkg::COEF_WIDTH_DEF,
   parameter int POINT_WIDTH = pss_pkg::POINT_WIDTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   pss_req_if.sink       req_ch,
   pss_rsp_if.source     rsp_ch,
   input  logic          psel,
   input  logic          penable,
   input  logic          pwrite,
   input  logic [5:0]    paddr,
   input  logic [63:0]   pwdata,
   output logic [63:0]   prdata,
   output logic          pready
);

   localparam int PCW = POINT_WIDTH + COEF_WIDTH;     // one product
   localparam int HW  = PCW + 2;                      // sum of four products
   localparam int MW  = HW + pss_pkg::SUBPIX_SHIFT;   // scaled numerator magnitude

   // ---------------- configuration registers ----------------
   logic [63:0] row_ff [4];
   logic [15:0] max_size_ff;
   logic [15:0] falloff_ff;
   logic        wr_en;
   logic [2:0]  wr_idx;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign wr_idx = paddr[5:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 4; r++) row_ff[r] <= '0;
         max_size_ff <= pss_pkg::MAX_SIZE_RST;
         falloff_ff  <= pss_pkg::FALLOFF_RST;
      end else if (wr_en) begin
         case (wr_idx)
            pss_pkg::REG_ROW0:    row_ff[0]   <= pwdata;
            pss_pkg::REG_ROW1:    row_ff[1]   <= pwdata;
            pss_pkg::REG_ROW2:    row_ff[2]   <= pwdata;
            pss_pkg::REG_ROW3:    row_ff[3]   <= pwdata;
            pss_pkg::REG_MAXSIZE: max_size_ff <= pwdata[15:0];
            pss_pkg::REG_FALLOFF: falloff_ff  <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   // register read back
   always_comb begin
      case (wr_idx)
         pss_pkg::REG_ROW0:    prdata = row_ff[0];
         pss_pkg::REG_ROW1:    prdata = row_ff[1];
         pss_pkg::REG_ROW2:    prdata = row_ff[2];
         pss_pkg::REG_ROW3:    prdata = row_ff[3];
         pss_pkg::REG_MAXSIZE: prdata = {48'd0, max_size_ff};
         pss_pkg::REG_FALLOFF: prdata = {48'd0, falloff_ff};
         default:              prdata = '0;
      endcase
   end

   // whole pipeline advances unless the output holds an untaken result
   logic en;
   logic out_v_ff;
   assign en           = !out_v_ff || rsp_ch.ready;
   assign req_ch.ready = en;

   // ---------------- stage 1: sixteen products ----------------
   logic signed [PCW-1:0] prod_ff [4][4];
   logic signed [PCW-1:0] prod_in [4][4];
   logic                  v1_ff, last1_ff;
   logic signed [POINT_WIDTH-1:0] pt [4];

   assign pt[0] = req_ch.point_x;
   assign pt[1] = req_ch.point_y;
   assign pt[2] = req_ch.point_z;
   assign pt[3] = req_ch.point_w;

   always_comb begin
      logic signed [COEF_WIDTH-1:0] cf;
      for (int r = 0; r < 4; r++) begin
         for (int j = 0; j < 4; j++) begin
            cf = row_ff[r][16*j +: COEF_WIDTH];
            prod_in[r][j] = cf * pt[r];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (en) v1_ff <= req_ch.valid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff  <= prod_in;
         last1_ff <= req_ch.last_point;
      end
   end

   // ---------------- stage 2: homogeneous sums ----------------
   logic signed [HW-1:0] h_ff [4];
   logic signed [HW-1:0] h_in [4];
   logic                 v2_ff, last2_ff;

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         h_in[j] = '0;
         for (int r = 0; r < 4; r++) begin
            h_in[j] = h_in[j] + {{2{prod_ff[r][j][PCW-1]}}, prod_ff[r][j]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (en) v2_ff <= v1_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         h_ff     <= h_in;
         last2_ff <= last1_ff;
      end
   end

   // ---------------- stage 3: magnitudes and signs ----------------
   logic [2:0][MW-1:0]  num_ff, num_in;
   logic [HW-1:0]       den_ff, den_in;
   pss_pkg::side_type   side3_ff, side3_in;
   logic                v3_ff;

   always_comb begin
      logic [HW-1:0] mag;
      for (int j = 0; j < 3; j++) begin
         mag = h_ff[j][HW-1] ? HW'(-h_ff[j]) : HW'(h_ff[j]);
         num_in[j]            = {mag, {pss_pkg::SUBPIX_SHIFT{1'b0}}};
         side3_in.num_neg[j]  = h_ff[j][HW-1];
         side3_in.num_zero[j] = (h_ff[j] == '0);
      end
      den_in          = h_ff[3][HW-1] ? HW'(-h_ff[3]) : HW'(h_ff[3]);
      side3_in.w_neg  = h_ff[3][HW-1];
      side3_in.w_zero = (h_ff[3] == '0);
      side3_in.last   = last2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (en) v3_ff <= v2_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff   <= num_in;
         den_ff   <= den_in;
         side3_ff <= side3_in;
      end
   end

   // ---------------- divider ----------------
   logic               dv_valid;
   pss_pkg::side_type  dv_side;
   logic [2:0][MW-1:0] dv_quo;

   pss_div3 #(
      .NW (MW),
      .DW (HW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v3_ff),
      .in_side   (side3_ff),
      .in_num    (num_ff),
      .in_den    (den_ff),
      .out_valid (dv_valid),
      .out_side  (dv_side),
      .out_quo   (dv_quo)
   );

   // ---------------- stage A: signed quotients, depth clamp ----------------
   localparam logic signed [63:0] FAR_OUT = 64'sd1 << 40;
   localparam logic signed [63:0] XY_LIM  = 64'sd131072;
   localparam logic signed [63:0] Z_MAX   = 64'sh0000_0000_FFFF_FFFF;

   logic signed [18:0] qx_a_ff, qy_a_ff, qx_a_in, qy_a_in;
   logic [31:0]        dep_a_ff, dep_a_in;
   logic               flag_a_ff, flag_a_in, last_a_ff, va_ff;

   always_comb begin
      logic signed [63:0] q [3];
      logic signed [63:0] mag64;
      for (int j = 0; j < 3; j++) begin
         mag64 = {{(64-MW){1'b0}}, dv_quo[j]};
         if (dv_side.w_zero) begin
            if (dv_side.num_zero[j])     q[j] = '0;
            else if (dv_side.num_neg[j]) q[j] = -FAR_OUT;
            else                         q[j] = FAR_OUT;
         end else begin
            q[j] = (dv_side.num_neg[j] ^ dv_side.w_neg) ? -mag64 : mag64;
         end
      end
      // x and y only need to stay beyond reach of the corner clamp
      if (q[0] > XY_LIM)       qx_a_in = 19'(XY_LIM);
      else if (q[0] < -XY_LIM) qx_a_in = 19'(-XY_LIM);
      else                     qx_a_in = q[0][18:0];
      if (q[1] > XY_LIM)       qy_a_in = 19'(XY_LIM);
      else if (q[1] < -XY_LIM) qy_a_in = 19'(-XY_LIM);
      else                     qy_a_in = q[1][18:0];
      flag_a_in = dv_side.w_zero;
      if (q[2] < 0) begin
         dep_a_in  = '0;
         flag_a_in = 1'b1;
      end else if (q[2] > Z_MAX) begin
         dep_a_in  = '1;
         flag_a_in = 1'b1;
      end else begin
         dep_a_in = q[2][31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) va_ff <= 1'b0;
      else if (en) va_ff <= dv_valid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         qx_a_ff   <= qx_a_in;
         qy_a_ff   <= qy_a_in;
         dep_a_ff  <= dep_a_in;
         flag_a_ff <= flag_a_in;
         last_a_ff <= dv_side.last;
      end
   end

   // ---------------- stage B: depth times falloff ----------------
   logic signed [18:0] qx_b_ff, qy_b_ff;
   logic [31:0]        dep_b_ff;
   logic [47:0]        dfp_b_ff;
   logic               flag_b_ff, last_b_ff, vb_ff;

   always_ff @(posedge clock) begin
      if (reset) vb_ff <= 1'b0;
      else if (en) vb_ff <= va_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         qx_b_ff   <= qx_a_ff;
         qy_b_ff   <= qy_a_ff;
         dep_b_ff  <= dep_a_ff;
         dfp_b_ff  <= dep_a_ff * falloff_ff;
         flag_b_ff <= flag_a_ff;
         last_b_ff <= last_a_ff;
      end
   end

   // ---------------- stage C: ceil by 2^17, clamp ----------------
   logic signed [18:0] qx_c_ff, qy_c_ff;
   logic [31:0]        dep_c_ff;
   logic [23:0]        u_c_ff, u_c_in;
   logic               flag_c_ff, last_c_ff, vc_ff;

   always_comb begin
      logic [48:0] sum;
      logic [31:0] u;
      sum = {1'b0, dfp_b_ff} + 49'((1 << pss_pkg::SIZE_SHIFT) - 1);
      u   = sum[48:pss_pkg::SIZE_SHIFT];
      u_c_in = (u > {8'd0, pss_pkg::U_CLAMP}) ? pss_pkg::U_CLAMP : u[23:0];
   end

   always_ff @(posedge clock) begin
      if (reset) vc_ff <= 1'b0;
      else if (en) vc_ff <= vb_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         qx_c_ff   <= qx_b_ff;
         qy_c_ff   <= qy_b_ff;
         dep_c_ff  <= dep_b_ff;
         u_c_ff    <= u_c_in;
         flag_c_ff <= flag_b_ff;
         last_c_ff <= last_b_ff;
      end
   end

   // ---------------- stage D: reciprocal multiply for ceil by 173 ----------------
   logic signed [18:0] qx_d_ff, qy_d_ff;
   logic [31:0]        dep_d_ff;
   logic [48:0]        vm_d_ff;
   logic [23:0]        v_d;
   logic               flag_d_ff, last_d_ff, vd_ff;

   assign v_d = u_c_ff + 24'(pss_pkg::SIZE_ODD - 1);

   always_ff @(posedge clock) begin
      if (reset) vd_ff <= 1'b0;
      else if (en) vd_ff <= vc_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         qx_d_ff   <= qx_c_ff;
         qy_d_ff   <= qy_c_ff;
         dep_d_ff  <= dep_c_ff;
         vm_d_ff   <= v_d * pss_pkg::SIZE_RECIP;
         flag_d_ff <= flag_c_ff;
         last_d_ff <= last_c_ff;
      end
   end

   // ---------------- stage E: sprite half-size ----------------
   logic signed [18:0] qx_e_ff, qy_e_ff;
   logic [31:0]        dep_e_ff;
   logic [15:0]        size_e_ff, size_e_in;
   logic [16:0]        t_e;
   logic               flag_e_ff, last_e_ff, ve_ff;

   assign t_e       = vm_d_ff[48:pss_pkg::RECIP_SHIFT];
   assign size_e_in = (t_e >= {1'b0, max_size_ff}) ? 16'd0 : (max_size_ff - t_e[15:0]);

   always_ff @(posedge clock) begin
      if (reset) ve_ff <= 1'b0;
      else if (en) ve_ff <= vd_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         qx_e_ff   <= qx_d_ff;
         qy_e_ff   <= qy_d_ff;
         dep_e_ff  <= dep_d_ff;
         size_e_ff <= size_e_in;
         flag_e_ff <= flag_d_ff;
         last_e_ff <= last_d_ff;
      end
   end

   // ---------------- stage F: corners, output register ----------------
   // clamp to 16 bits unsigned, MSB of the result reports a clamp
   function automatic logic [16:0] clamp16(input logic signed [19:0] v);
      logic [16:0] res;
      if (v < 0)                 res = {1'b1, 16'd0};
      else if (v > 20'sd65535)   res = {1'b1, 16'hFFFF};
      else                       res = {1'b0, v[15:0]};
      return res;
   endfunction

   logic signed [19:0] sz_s;
   logic [16:0]        c0x, c0y, c1x, c1y;
   logic [15:0]        c0x_ff, c0y_ff, c1x_ff, c1y_ff, size_f_ff;
   logic [31:0]        dep_f_ff;
   logic               flag_f_ff, last_f_ff;

   assign sz_s = {4'd0, size_e_ff};
   assign c0x  = clamp16({qx_e_ff[18], qx_e_ff} - sz_s);
   assign c0y  = clamp16({qy_e_ff[18], qy_e_ff} - sz_s);
   assign c1x  = clamp16({qx_e_ff[18], qx_e_ff} + sz_s);
   assign c1y  = clamp16({qy_e_ff[18], qy_e_ff} + sz_s);

   always_ff @(posedge clock) begin
      if (reset) out_v_ff <= 1'b0;
      else if (en) out_v_ff <= ve_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c0x_ff    <= c0x[15:0];
         c0y_ff    <= c0y[15:0];
         c1x_ff    <= c1x[15:0];
         c1y_ff    <= c1y[15:0];
         dep_f_ff  <= dep_e_ff;
         size_f_ff <= size_e_ff;
         flag_f_ff <= flag_e_ff | c0x[16] | c0y[16] | c1x[16] | c1y[16];
         last_f_ff <= last_e_ff;
      end
   end

   assign rsp_ch.valid       = out_v_ff;
   assign rsp_ch.corner0_x   = c0x_ff;
   assign rsp_ch.corner0_y   = c0y_ff;
   assign rsp_ch.corner1_x   = c1x_ff;
   assign rsp_ch.corner1_y   = c1y_ff;
   assign rsp_ch.depth       = dep_f_ff;
   assign rsp_ch.half_size   = size_f_ff;
   assign rsp_ch.range_flag  = flag_f_ff;
   assign rsp_ch.last_sprite = last_f_ff;

   // ---------------- assertions ----------------
   // half-size never exceeds the configured maximum
   a_size_max: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.half_size <= max_size_ff))
      else $error("half_size above max_size");

   // corners are ordered and no further apart in x than the full sprite
   a_corner_order: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.corner1_x >= rsp_ch.corner0_x &&
                        rsp_ch.corner1_y >= rsp_ch.corner0_y &&
                        (17'(rsp_ch.corner1_x) - 17'(rsp_ch.corner0_x))
                           <= {rsp_ch.half_size, 1'b0}))
      else $error("sprite corners inconsistent with half_size");

   // a result with no flag must keep its full width in x, unshortened by clamping
   a_flag_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.range_flag) |->
         (17'(rsp_ch.corner1_x) - 17'(rsp_ch.corner0_x)) == {rsp_ch.half_size, 1'b0})
      else $error("unflagged sprite lost width to clamping");

endmodule
